/* rtl/jads_pkg.sv */
// Package: widths, register map, reset values and transaction structs of the axis scaler.
`timescale 1ns / 1ps

package jads_pkg;

  localparam int SAMPLE_W   = 10;
  localparam int OFFS_W     = 8;
  localparam int SCALE_W    = 10;
  localparam int MASK_W     = 3;
  localparam int AXIS_W     = 8;
  localparam int BTN_W      = 6;
  localparam int NUM_AXES   = 3;
  localparam int DIFF_W     = 12;
  localparam int MAG_W      = 10;
  localparam int Q_BITS     = 7;
  localparam int NUM_W      = 19;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // lane: prep, numerator, one stage per quotient bit, sign/clamp
  localparam int LANE_LAT   = Q_BITS + 3;
  localparam int RESULT_LAT = LANE_LAT + 1;

  localparam logic signed [DIFF_W-1:0] CENTRE    = 12'sd512;
  localparam logic signed [DIFF_W-1:0] DEAD_HALF = 12'sd12;
  localparam logic [NUM_W-1:0]         GAIN_X2   = 19'd508;
  localparam logic [Q_BITS-1:0]        Q_MAX     = 7'd127;

  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_SCALE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 3'd6;

  localparam logic signed [OFFS_W-1:0] X_OFFSET_RST = 8'sd23;
  localparam logic [SCALE_W-1:0]       X_SCALE_RST  = 10'd210;
  localparam logic signed [OFFS_W-1:0] Y_OFFSET_RST = 8'sd25;
  localparam logic [SCALE_W-1:0]       Y_SCALE_RST  = 10'd220;
  localparam logic signed [OFFS_W-1:0] Z_OFFSET_RST = 8'sd31;
  localparam logic [SCALE_W-1:0]       Z_SCALE_RST  = 10'd230;
  localparam logic [MASK_W-1:0]        INVERT_RST   = 3'd5;

  typedef struct packed {
    logic [SAMPLE_W-1:0] x_sample;
    logic [SAMPLE_W-1:0] y_sample;
    logic [SAMPLE_W-1:0] z_sample;
    logic [BTN_W-1:0]    buttons_raw;
  } in_item_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0] x_axis;
    logic signed [AXIS_W-1:0] y_axis;
    logic signed [AXIS_W-1:0] z_axis;
    logic [BTN_W-1:0]         buttons_pressed;
  } result_t;

endpackage

/* rtl/jads_lane.sv */
// One axis lane: dead band, offset removal, pipelined restoring divide, clamp and sign.
`timescale 1ns / 1ps

module jads_lane (
  input  logic                                 clk,
  input  logic [jads_pkg::SAMPLE_W-1:0]        sample,
  input  logic signed [jads_pkg::OFFS_W-1:0]   offset,
  input  logic [jads_pkg::SCALE_W-1:0]         scale,
  input  logic                                 neg,
  output logic signed [jads_pkg::AXIS_W-1:0]   axis
);

  localparam int NSTG = jads_pkg::Q_BITS + 1;

  logic signed [jads_pkg::DIFF_W-1:0] d;
  logic [jads_pkg::DIFF_W-1:0]        dabs;
  logic [jads_pkg::DIFF_W-1:0]        mag_full;
  logic [jads_pkg::SCALE_W-1:0]       scl_eff;

  // prep stage
  logic                         dead_a;
  logic                         negt_a;
  logic                         inv_a;
  logic [jads_pkg::MAG_W-1:0]   mag_a;
  logic [jads_pkg::SCALE_W-1:0] scl_a;

  // divide stages, index 0 holds the numerator stage
  logic [jads_pkg::NUM_W-1:0]   rem   [0:NSTG-1];
  logic [jads_pkg::Q_BITS-1:0]  quo   [0:NSTG-1];
  logic [jads_pkg::SCALE_W-1:0] scl_s [0:NSTG-1];
  logic                         sat_s [0:NSTG-1];
  logic                         dead_s[0:NSTG-1];
  logic                         flip_s[0:NSTG-1];

  logic [jads_pkg::Q_BITS-1:0] qm;
  logic signed [jads_pkg::AXIS_W-1:0] v;

  always_comb begin
    d = $signed({2'b00, sample}) - jads_pkg::CENTRE
        - {{(jads_pkg::DIFF_W-jads_pkg::OFFS_W){offset[jads_pkg::OFFS_W-1]}}, offset};
    dabs = d[jads_pkg::DIFF_W-1] ? jads_pkg::DIFF_W'(-d) : jads_pkg::DIFF_W'(d);
    mag_full = dabs - jads_pkg::DIFF_W'(jads_pkg::DEAD_HALF);
    scl_eff = (scale == '0) ? jads_pkg::SCALE_W'(1) : scale;
  end

  always_ff @(posedge clk) begin
    dead_a <= (d > -jads_pkg::DEAD_HALF) && (d < jads_pkg::DEAD_HALF);
    negt_a <= d[jads_pkg::DIFF_W-1];
    inv_a  <= neg;
    mag_a  <= mag_full[jads_pkg::MAG_W-1:0];
    scl_a  <= scl_eff;
  end

  // numerator 2*|t|*254 + scale; saturate when quotient would exceed 127
  logic [jads_pkg::NUM_W-1:0] num;
  always_comb begin
    num = jads_pkg::NUM_W'(mag_a) * jads_pkg::GAIN_X2 + jads_pkg::NUM_W'(scl_a);
  end

  always_ff @(posedge clk) begin
    rem[0]    <= num;
    quo[0]    <= '0;
    scl_s[0]  <= scl_a;
    sat_s[0]  <= num >= (jads_pkg::NUM_W'(scl_a) << (jads_pkg::Q_BITS + 1));
    dead_s[0] <= dead_a;
    flip_s[0] <= negt_a ^ inv_a;
  end

  genvar k;
  generate
    for (k = 0; k < jads_pkg::Q_BITS; k++) begin : g_step
      localparam int SH = jads_pkg::Q_BITS - k;
      logic [jads_pkg::NUM_W-1:0] dsh;
      logic                       ge;
      always_comb begin
        dsh = jads_pkg::NUM_W'(scl_s[k]) << SH;
        ge  = rem[k] >= dsh;
      end
      always_ff @(posedge clk) begin
        rem[k+1]    <= ge ? rem[k] - dsh : rem[k];
        quo[k+1]    <= {quo[k][jads_pkg::Q_BITS-2:0], ge};
        scl_s[k+1]  <= scl_s[k];
        sat_s[k+1]  <= sat_s[k];
        dead_s[k+1] <= dead_s[k];
        flip_s[k+1] <= flip_s[k];
      end
    end
  endgenerate

  always_comb begin
    qm = sat_s[NSTG-1] ? jads_pkg::Q_MAX : quo[NSTG-1];
    v  = $signed({1'b0, qm});
  end

  always_ff @(posedge clk) begin
    if (dead_s[NSTG-1]) begin
      axis <= '0;
    end else if (flip_s[NSTG-1]) begin
      axis <= -v;
    end else begin
      axis <= v;
    end
  end

endmodule

/* rtl/joystick_axis_deadzone_scaler.sv */
// Top level: configuration registers, three axis lanes and the report merge stage.
// Throughput: one transaction per cycle; busy is always low.
// Each lane runs a 7-stage restoring divider, one quotient bit per stage.
// Reset (rst, synchronous): registers return to their defaults, in-flight work is dropped.
// The result is shown for one cycle on done; the receiver cannot stall.
`timescale 1ns / 1ps

module joystick_axis_deadzone_scaler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  jads_pkg::in_item_t                 in_item,
  output logic                               done,
  output jads_pkg::result_t                  result,
  input  logic                               cfg_we,
  input  logic [jads_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [jads_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic signed [jads_pkg::OFFS_W-1:0] offset_r [0:jads_pkg::NUM_AXES-1];
  logic [jads_pkg::SCALE_W-1:0]       scale_r  [0:jads_pkg::NUM_AXES-1];
  logic [jads_pkg::MASK_W-1:0]        invert_mask;

  logic [jads_pkg::SAMPLE_W-1:0]      samp     [0:jads_pkg::NUM_AXES-1];
  logic signed [jads_pkg::AXIS_W-1:0] axis_l   [0:jads_pkg::NUM_AXES-1];

  logic [jads_pkg::LANE_LAT-1:0]      vld;
  logic [jads_pkg::BTN_W-1:0]         btn_d    [0:jads_pkg::LANE_LAT-1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_r[0] <= jads_pkg::X_OFFSET_RST;
      scale_r[0]  <= jads_pkg::X_SCALE_RST;
      offset_r[1] <= jads_pkg::Y_OFFSET_RST;
      scale_r[1]  <= jads_pkg::Y_SCALE_RST;
      offset_r[2] <= jads_pkg::Z_OFFSET_RST;
      scale_r[2]  <= jads_pkg::Z_SCALE_RST;
      invert_mask <= jads_pkg::INVERT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jads_pkg::CFG_X_OFFSET:    offset_r[0] <= $signed(cfg_data[jads_pkg::OFFS_W-1:0]);
        jads_pkg::CFG_X_SCALE:     scale_r[0]  <= cfg_data[jads_pkg::SCALE_W-1:0];
        jads_pkg::CFG_Y_OFFSET:    offset_r[1] <= $signed(cfg_data[jads_pkg::OFFS_W-1:0]);
        jads_pkg::CFG_Y_SCALE:     scale_r[1]  <= cfg_data[jads_pkg::SCALE_W-1:0];
        jads_pkg::CFG_Z_OFFSET:    offset_r[2] <= $signed(cfg_data[jads_pkg::OFFS_W-1:0]);
        jads_pkg::CFG_Z_SCALE:     scale_r[2]  <= cfg_data[jads_pkg::SCALE_W-1:0];
        jads_pkg::CFG_INVERT_MASK: invert_mask <= cfg_data[jads_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign samp[0] = in_item.x_sample;
  assign samp[1] = in_item.y_sample;
  assign samp[2] = in_item.z_sample;

  genvar a;
  generate
    for (a = 0; a < jads_pkg::NUM_AXES; a++) begin : g_lane
      jads_lane u_lane (
        .clk    (clk),
        .sample (samp[a]),
        .offset (offset_r[a]),
        .scale  (scale_r[a]),
        .neg    (invert_mask[a]),
        .axis   (axis_l[a])
      );
    end
  endgenerate

  // transaction tracking alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[jads_pkg::LANE_LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    btn_d[0] <= ~in_item.buttons_raw;
    for (int i = 1; i < jads_pkg::LANE_LAT; i++) begin
      btn_d[i] <= btn_d[i-1];
    end
  end

  // merge stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[jads_pkg::LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    result.x_axis          <= axis_l[0];
    result.y_axis          <= axis_l[1];
    result.z_axis          <= axis_l[2];
    result.buttons_pressed <= btn_d[jads_pkg::LANE_LAT-1];
  end

endmodule

/* rtl/jads_checker.sv */
// Port-level checker for the axis scaler, bound to the top level.
`timescale 1ns / 1ps

module jads_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input jads_pkg::in_item_t              in_item,
  input logic                            done,
  input jads_pkg::result_t               result,
  input logic                            cfg_we,
  input logic [jads_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [jads_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam logic [jads_pkg::AXIS_W-1:0] AXIS_MIN_CODE = 8'h80;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, jads_pkg::RESULT_LAT))
    else $error("report without a transaction");

  a_start_gives_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(jads_pkg::RESULT_LAT) done)
    else $error("transaction lost");

  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.x_axis != AXIS_MIN_CODE) && (result.y_axis != AXIS_MIN_CODE)
             && (result.z_axis != AXIS_MIN_CODE))
    else $error("axis outside +-127");

  a_buttons: assert property (@(posedge clk) disable iff (rst)
    done |-> result.buttons_pressed == ~$past(in_item.buttons_raw, jads_pkg::RESULT_LAT))
    else $error("buttons mismatch");

endmodule

bind joystick_axis_deadzone_scaler jads_checker u_jads_checker (.*);
